@@ hdl/mfd_pkg.sv @@
// Shared constants, codes and types for the membership failure detector.
// No dependencies; imported by membership_failure_detector_core.
package mfd_pkg;

  localparam int MAX_MEMBERS = 32;
  localparam int TIME_BITS   = 32;
  localparam int COUNT_BITS  = 8;

  localparam int IDX_BITS    = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
  localparam int CNT_BITS    = $clog2(MAX_MEMBERS + 1);
  localparam int CMP_BITS    = (COUNT_BITS > 8) ? COUNT_BITS : 8;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [7:0]  FAILURES_RESET = 8'd3;
  localparam logic [5:0]  MEMBERS_RESET = 6'd0;

  typedef enum logic [1:0] {
    OP_PING   = 2'd0,
    OP_ACK    = 2'd1,
    OP_DETECT = 2'd2,
    OP_STATUS = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_TIMEOUT  = 2'd0,
    REG_FAILURES = 2'd1,
    REG_MEMBERS  = 2'd2,
    REG_NONE     = 2'd3
  } reg_idx_t;

  localparam logic [1:0] ST_ALIVE      = 2'd0;
  localparam logic [1:0] ST_SUSPICIOUS = 2'd1;
  localparam logic [1:0] ST_DEAD       = 2'd2;

endpackage

@@ hdl/membership_failure_detector_core.sv @@
// Per-member failure-detector table with a sequenced detect scan; depends on mfd_pkg.
// Ping, ack and set status are accepted whenever start is high and busy is low, return no beat and keep busy low.
// Detect holds busy while one shared subtract-and-compare unit judges each entry in use
// in turn (ping time read from memory, then evaluate), followed by a flush state.
// Event beats strobe during the scan; the final beat shows in the cycle busy falls, and
// the receiver cannot stall. Synchronous reset clears all but ping times and data registers.
module membership_failure_detector_core
  import mfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  operation,
  input  logic [4:0]  member,
  input  logic [31:0] now_ms,
  input  logic [1:0]  new_status,
  input  logic        config_write,
  input  logic [1:0]  config_index,
  input  logic [15:0] config_data,
  output logic        result_strobe,
  output logic [4:0]  event_member,
  output logic [1:0]  event_status,
  output logic        event_valid,
  output logic        last
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_EVAL,
    S_FLUSH
  } state_t;

  state_t state;

  logic [15:0] timeout_ms;
  logic [7:0]  failures_before_dead;
  logic [5:0]  member_count;

  logic                  waiting_flag [MAX_MEMBERS];
  logic [COUNT_BITS-1:0] failure_count [MAX_MEMBERS];
  logic [1:0]            member_status [MAX_MEMBERS];
  logic [TIME_BITS-1:0]  ping_mem [MAX_MEMBERS];

  logic [TIME_BITS-1:0]  ping_rd;
  logic [TIME_BITS-1:0]  now_reg;
  logic [CNT_BITS-1:0]   scan_idx;
  logic [CNT_BITS-1:0]   used;
  logic [IDX_BITS-1:0]   pend_member;
  logic [1:0]            pend_status;
  logic                  pend_valid;

  logic                  accept;
  logic [IDX_BITS-1:0]   member_idx;
  logic                  member_ok;
  logic [CNT_BITS-1:0]   used_next;
  logic [CNT_BITS-1:0]   scan_idx_next;
  logic [IDX_BITS-1:0]   cur;
  logic [TIME_BITS-1:0]  diff;
  logic                  expired;
  logic [1:0]            judged;
  logic                  worse;

  assign busy       = (state != S_IDLE);
  assign accept     = start && !busy;
  assign member_idx = IDX_BITS'(member);
  assign member_ok  = (int'(member) < MAX_MEMBERS);
  assign used_next  = (int'(member_count) > MAX_MEMBERS) ? CNT_BITS'(MAX_MEMBERS)
                                                         : CNT_BITS'(member_count);
  assign scan_idx_next = scan_idx + 1'b1;
  assign cur           = scan_idx[IDX_BITS-1:0];

  // The shared unit: modular elapsed time against the timeout.
  assign diff    = now_reg - ping_rd;
  assign expired = waiting_flag[cur] && (diff > TIME_BITS'(timeout_ms));
  assign judged  = (CMP_BITS'(failure_count[cur]) >= CMP_BITS'(failures_before_dead))
                   ? ST_DEAD : ST_SUSPICIOUS;
  assign worse   = expired && (judged > member_status[cur]);

  always_ff @(posedge clk) begin
    if (accept && (op_t'(operation) == OP_PING) && member_ok) begin
      ping_mem[member_idx] <= now_ms[TIME_BITS-1:0];
    end
    if (state == S_READ) begin
      ping_rd <= ping_mem[cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      timeout_ms           <= TIMEOUT_RESET;
      failures_before_dead <= FAILURES_RESET;
      member_count         <= MEMBERS_RESET;
      pend_valid           <= 1'b0;
      result_strobe        <= 1'b0;
      event_valid          <= 1'b0;
      last                 <= 1'b0;
      scan_idx             <= '0;
      used                 <= '0;
      for (int i = 0; i < MAX_MEMBERS; i++) begin
        waiting_flag[i]  <= 1'b0;
        failure_count[i] <= '0;
        member_status[i] <= ST_ALIVE;
      end
    end else begin
      result_strobe <= 1'b0;
      if (config_write) begin
        case (reg_idx_t'(config_index))
          REG_TIMEOUT:  timeout_ms           <= config_data;
          REG_FAILURES: failures_before_dead <= config_data[7:0];
          REG_MEMBERS:  member_count         <= config_data[5:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op_t'(operation))
              OP_PING: begin
                if (member_ok) begin
                  waiting_flag[member_idx] <= 1'b1;
                end
              end
              OP_ACK: begin
                if (member_ok) begin
                  waiting_flag[member_idx]  <= 1'b0;
                  failure_count[member_idx] <= '0;
                end
              end
              OP_STATUS: begin
                if (member_ok) begin
                  member_status[member_idx] <= (new_status > ST_DEAD) ? ST_DEAD
                                                                      : new_status;
                end
              end
              OP_DETECT: begin
                now_reg    <= now_ms[TIME_BITS-1:0];
                used       <= used_next;
                scan_idx   <= '0;
                pend_valid <= 1'b0;
                state      <= (used_next == '0) ? S_FLUSH : S_READ;
              end
              default: ;
            endcase
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (expired) begin
            waiting_flag[cur] <= 1'b0;
            if (failure_count[cur] != '1) begin
              failure_count[cur] <= failure_count[cur] + 1'b1;
            end
          end
          if (worse) begin
            member_status[cur] <= judged;
            // An earlier event is known not to be the last one now.
            if (pend_valid) begin
              result_strobe <= 1'b1;
              event_member  <= 5'(pend_member);
              event_status  <= pend_status;
              event_valid   <= 1'b1;
              last          <= 1'b0;
            end
            pend_valid  <= 1'b1;
            pend_member <= cur;
            pend_status <= judged;
          end
          scan_idx <= scan_idx_next;
          state    <= (scan_idx_next == used) ? S_FLUSH : S_READ;
        end
        S_FLUSH: begin
          result_strobe <= 1'b1;
          last          <= 1'b1;
          event_valid   <= pend_valid;
          event_member  <= pend_valid ? 5'(pend_member) : 5'd0;
          event_status  <= pend_valid ? pend_status : ST_ALIVE;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_scan_ends_with_last: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(busy)) |-> (result_strobe && last))
    else $error("detect scan ended without a final beat");

  a_event_status_code: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && event_valid) |-> (event_status == ST_SUSPICIOUS ||
                                        event_status == ST_DEAD))
    else $error("event beat carries an invalid status");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !event_valid) |->
      (last && event_member == 5'd0 && event_status == ST_ALIVE))
    else $error("empty beat is malformed");

  a_detect_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && op_t'(operation) == OP_DETECT) |=> busy)
    else $error("detect accepted without starting a scan");

  a_mid_scan_beat: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && !last) |-> busy)
    else $error("non-final beat outside a scan");

endmodule

@@ sim/membership_failure_detector_core_tb.sv @@
// Self-checking testbench for membership_failure_detector_core: directed and random
// ping, ack, set-status and detect beats checked against a built-in table predictor.
// Depends on mfd_pkg and the core RTL only.
`timescale 1ns / 1ps

module membership_failure_detector_core_tb
  import mfd_pkg::*;
();

  typedef struct {
    op_t         op;
    logic [4:0]  who;
    logic [31:0] now;
    logic [1:0]  status;
  } command_t;

  typedef struct {
    logic [4:0] who;
    logic [1:0] status;
    logic       valid;
    logic       fin;
  } status_event_t;

  localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  operation = 2'd0;
  logic [4:0]  member = 5'd0;
  logic [31:0] now_ms = 32'd0;
  logic [1:0]  new_status = 2'd0;
  logic        config_write = 1'b0;
  logic [1:0]  config_index = 2'd0;
  logic [15:0] config_data = 16'd0;
  logic        result_strobe;
  logic [4:0]  event_member;
  logic [1:0]  event_status;
  logic        event_valid;
  logic        last;

  command_t      command_queue[$];
  status_event_t expected_events[$];
  command_t      cur_cmd;
  int            mismatch_count = 0;
  int            burst_left = 1;
  int            gap_left = 0;
  logic [31:0]   clock_ms = 32'd0;

  logic [15:0]           cfg_timeout = TIMEOUT_RESET;
  logic [7:0]            cfg_fail_limit = FAILURES_RESET;
  logic [5:0]            cfg_members = MEMBERS_RESET;
  logic                  waiting [MAX_MEMBERS];
  logic [TIME_BITS-1:0]  ping_at [MAX_MEMBERS];
  logic [COUNT_BITS-1:0] fail_cnt [MAX_MEMBERS];
  logic [1:0]            entry_status [MAX_MEMBERS];

  membership_failure_detector_core u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .member(member),
    .now_ms(now_ms),
    .new_status(new_status),
    .config_write(config_write),
    .config_index(config_index),
    .config_data(config_data),
    .result_strobe(result_strobe),
    .event_member(event_member),
    .event_status(event_status),
    .event_valid(event_valid),
    .last(last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  task automatic apply_command(command_t c);
    status_event_t scan[$];
    int in_use;
    logic [TIME_BITS-1:0] elapsed;
    logic [1:0] judged;
    case (c.op)
      OP_PING: begin
        waiting[c.who] = 1'b1;
        ping_at[c.who] = c.now;
      end
      OP_ACK: begin
        waiting[c.who] = 1'b0;
        fail_cnt[c.who] = '0;
      end
      OP_STATUS: begin
        entry_status[c.who] = (c.status > ST_DEAD) ? ST_DEAD : c.status;
      end
      default: begin
        in_use = (cfg_members > MAX_MEMBERS) ? MAX_MEMBERS : int'(cfg_members);
        for (int i = 0; i < in_use; i++) begin
          if (!waiting[i]) continue;
          elapsed = c.now - ping_at[i];
          if (elapsed <= cfg_timeout) continue;
          judged = (fail_cnt[i] >= cfg_fail_limit) ? ST_DEAD : ST_SUSPICIOUS;
          if (fail_cnt[i] != COUNT_TOP) fail_cnt[i]++;
          waiting[i] = 1'b0;
          if (judged > entry_status[i]) begin
            entry_status[i] = judged;
            scan.insert(scan.size(), status_event_t'{5'(i), judged, 1'b1, 1'b0});
          end
        end
        if (scan.size() == 0) begin
          scan.insert(scan.size(), status_event_t'{5'd0, ST_ALIVE, 1'b0, 1'b1});
        end
        scan[scan.size() - 1].fin = 1'b1;
        foreach (scan[k]) expected_events.insert(expected_events.size(), scan[k]);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(cur_cmd);
      end
      if (!start || !busy) begin
        if (gap_left > 0 || command_queue.size() == 0) begin
          if (gap_left > 0) gap_left--;
          start <= 1'b0;
        end else begin
          cur_cmd = command_queue.pop_front();
          operation <= cur_cmd.op;
          member <= cur_cmd.who;
          now_ms <= cur_cmd.now;
          new_status <= cur_cmd.status;
          start <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 9);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    status_event_t want;
    if (!rst && result_strobe) begin
      if (expected_events.size() == 0) begin
        report_mismatch($sformatf("unexpected result member=%0d status=%0d valid=%0b last=%0b",
                                  event_member, event_status, event_valid, last));
      end else begin
        want = expected_events.pop_front();
        if (event_member !== want.who || event_status !== want.status ||
            event_valid !== want.valid || last !== want.fin) begin
          report_mismatch($sformatf(
            "got member=%0d status=%0d valid=%0b last=%0b, want %0d %0d %0b %0b",
            event_member, event_status, event_valid, last,
            want.who, want.status, want.valid, want.fin));
        end
      end
    end
  end

  task automatic add(op_t op, int who, logic [31:0] t, logic [1:0] s);
    command_queue.insert(command_queue.size(), command_t'{op, 5'(who), t, s});
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] data);
    @(posedge clk);
    config_write <= 1'b1;
    config_index <= idx;
    config_data <= data;
    @(posedge clk);
    config_write <= 1'b0;
    case (idx)
      REG_TIMEOUT:  cfg_timeout = data;
      REG_FAILURES: cfg_fail_limit = data[7:0];
      REG_MEMBERS:  cfg_members = data[5:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    do @(posedge clk); while (command_queue.size() != 0 || start || busy);
    while (expected_events.size() != 0 && waited < 200) begin
      @(posedge clk);
      waited++;
    end
    if (expected_events.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", expected_events.size()));
      expected_events.delete();
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic gen_random(int count);
    int in_use;
    int span;
    int pick;
    int who;
    in_use = (cfg_members > MAX_MEMBERS) ? MAX_MEMBERS : int'(cfg_members);
    span = cfg_timeout / 2 + 2;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 24) == 0) clock_ms = $urandom;
      else clock_ms += $urandom_range(0, span);
      if (in_use > 0 && $urandom_range(0, 4) != 0) who = $urandom_range(0, in_use - 1);
      else who = $urandom_range(0, 31);
      pick = $urandom_range(0, 19);
      if (pick < 7) add(OP_PING, who, clock_ms, 2'($urandom_range(0, 3)));
      else if (pick < 10) add(OP_ACK, who, $urandom, 2'($urandom_range(0, 3)));
      else if (pick < 15) add(OP_DETECT, $urandom_range(0, 31), clock_ms,
                              2'($urandom_range(0, 3)));
      else if ($urandom_range(0, 2) == 0) add(OP_STATUS, who, $urandom, 2'($urandom_range(1, 3)));
      else add(OP_STATUS, who, $urandom, ST_ALIVE);
    end
  endtask

  initial begin
    foreach (waiting[i]) begin
      waiting[i] = 1'b0;
      ping_at[i] = '0;
      fail_cnt[i] = '0;
      entry_status[i] = ST_ALIVE;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // With no members in use every scan comes back empty.
    add(OP_DETECT, 0, 32'd0, 2'd0);
    add(OP_PING, 0, 32'd5, 2'd0);
    add(OP_DETECT, 0, 32'd5000, 2'd0);
    drain();

    write_reg(REG_MEMBERS, 16'd32);
    write_reg(REG_TIMEOUT, 16'hFFFF);
    write_reg(REG_FAILURES, 16'd0);
    write_reg(REG_NONE, 16'hFFFF);
    add(OP_PING, 0, 32'd100, 2'd0);
    add(OP_PING, 31, 32'hFFFF_FFF0, 2'd0);
    add(OP_PING, 5, 32'd200, 2'd0);
    add(OP_STATUS, 7, 32'd0, 2'd3);
    add(OP_DETECT, 0, 32'd100 + 32'd65535, 2'd0);
    add(OP_DETECT, 0, 32'd100 + 32'd65536, 2'd0);
    add(OP_STATUS, 0, 32'd0, ST_ALIVE);
    add(OP_ACK, 31, 32'hFFFF_FFFF, 2'd3);
    add(OP_STATUS, 5, 32'd0, ST_SUSPICIOUS);
    add(OP_DETECT, 0, 32'd70200, 2'd0);
    drain();

    write_reg(REG_MEMBERS, 16'd63);
    write_reg(REG_TIMEOUT, 16'd1);
    write_reg(REG_FAILURES, 16'd255);
    add(OP_PING, 1, 32'd10, 2'd0);
    add(OP_PING, 2, 32'd10, 2'd0);
    add(OP_PING, 30, 32'd10, 2'd0);
    add(OP_DETECT, 0, 32'd11, 2'd0);
    add(OP_DETECT, 0, 32'd12, 2'd0);
    add(OP_STATUS, 2, 32'd0, ST_DEAD);
    add(OP_STATUS, 1, 32'd0, ST_ALIVE);
    add(OP_PING, 1, 32'd20, 2'd0);
    add(OP_PING, 2, 32'd20, 2'd0);
    add(OP_DETECT, 0, 32'd25, 2'd0);
    add(OP_ACK, 1, 32'd0, 2'd0);
    drain();

    // Climb one entry's failure count past the dead threshold.
    write_reg(REG_MEMBERS, 16'd1);
    write_reg(REG_FAILURES, 16'd40);
    clock_ms = 32'd1000;
    for (int k = 0; k < 60; k++) begin
      add(OP_PING, 0, clock_ms, 2'd0);
      clock_ms += 2;
      add(OP_DETECT, 0, clock_ms, 2'd0);
      if (k % 50 == 49) add(OP_STATUS, 0, clock_ms, ST_ALIVE);
    end
    add(OP_ACK, 0, clock_ms, 2'd0);
    drain();

    for (int k = 0; k < 6; k++) begin
      write_reg(REG_TIMEOUT, (k == 0) ? 16'd1 :
                             (k == 1) ? 16'hFFFF : 16'($urandom_range(2, 5000)));
      write_reg(REG_FAILURES, (k == 2) ? 16'd0 :
                              (k == 3) ? 16'hFFFF : 16'($urandom_range(0, 5)));
      write_reg(REG_MEMBERS, (k == 4) ? 16'hFFFF :
                             (k == 5) ? 16'($urandom_range(0, 63)) :
                                        16'($urandom_range(1, 32)));
      write_reg(REG_NONE, 16'($urandom));
      gen_random(30);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ membership_failure_detector_core.f @@
hdl/mfd_pkg.sv
hdl/membership_failure_detector_core.sv
sim/membership_failure_detector_core_tb.sv
